@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk with the asynchronous reset masked.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define LCDNW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication checked on the following clock edge.
`define LCDNW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/lcdnw_pkg.sv @@
// ---------------------------------------------------------------------------
// lcdnw_pkg
// Types, constants and tables shared by the LCD nibble write sequencer.
// ---------------------------------------------------------------------------
package lcdnw_pkg;

	localparam int unsigned LCDNW_QUEUE_DEPTH = 4;

	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned IN_TUSER_W  = 2;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned HOLD_W      = 16;

	localparam logic [15:0] STEP_HOLD_RESET   = 16'd1000;
	localparam logic [15:0] SETTLE_HOLD_RESET = 16'd100;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_HOLD   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_HOLD = 8'd1;

	// request codes
	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_CMD    = 2'd1,
		OP_DATA   = 2'd2,
		OP_CURSOR = 2'd3
	} op_t;

	typedef enum logic {
		JOB_BYTE  = 1'b0,
		JOB_PAUSE = 1'b1
	} job_kind_t;

	// one unit of work for the back end
	typedef struct packed {
		job_kind_t  kind;
		logic       sel;     // register select for a byte
		logic [7:0] val;     // byte to send
		logic       settle;  // pause uses the cursor settle hold
		logic       last;    // final job of the request
	} job_t;

	// power-up command bytes
	localparam logic [7:0] INIT_B0 = 8'h33;
	localparam logic [7:0] INIT_B1 = 8'h32;
	localparam logic [7:0] INIT_B2 = 8'h28;
	localparam logic [7:0] INIT_B3 = 8'h0e;
	localparam logic [7:0] INIT_B4 = 8'h01;
	localparam logic [7:0] INIT_B5 = 8'h06;

	localparam logic [2:0] INIT_LAST_IDX = 3'd7;

	function automatic job_t byte_job(logic sel, logic [7:0] val, logic last);
		job_t j;
		j.kind   = JOB_BYTE;
		j.sel    = sel;
		j.val    = val;
		j.settle = 1'b0;
		j.last   = last;
		return j;
	endfunction

	function automatic job_t pause_job(logic settle, logic last);
		job_t j;
		j.kind   = JOB_PAUSE;
		j.sel    = 1'b0;
		j.val    = 8'h00;
		j.settle = settle;
		j.last   = last;
		return j;
	endfunction

	// init sequence: pause, 33, 32, 28, 0E, 01, pause, 06
	function automatic job_t init_job(logic [2:0] idx);
		job_t j;
		case (idx)
			3'd0: j = pause_job(1'b0, 1'b0);
			3'd1: j = byte_job(1'b0, INIT_B0, 1'b0);
			3'd2: j = byte_job(1'b0, INIT_B1, 1'b0);
			3'd3: j = byte_job(1'b0, INIT_B2, 1'b0);
			3'd4: j = byte_job(1'b0, INIT_B3, 1'b0);
			3'd5: j = byte_job(1'b0, INIT_B4, 1'b0);
			3'd6: j = pause_job(1'b0, 1'b0);
			3'd7: j = byte_job(1'b0, INIT_B5, 1'b1);
			default: j = pause_job(1'b0, 1'b0);
		endcase
		return j;
	endfunction

	// DDRAM base address of each row, chosen by (row - 1) mod 4
	function automatic logic [7:0] row_base(logic [2:0] row);
		logic [1:0] idx;
		logic [7:0] b;
		idx = row[1:0] + 2'd3;
		case (idx)
			2'd0: b = 8'h80;
			2'd1: b = 8'hc0;
			2'd2: b = 8'h94;
			2'd3: b = 8'hd4;
			default: b = 8'h80;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// ---------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// 4-bit character LCD write sequencer: requests in, timed pin states out.
// ---------------------------------------------------------------------------
// Each input item is one request (tuser): power-up init, command byte, data
// byte or cursor move. Every output item is one pin state for the display
// (D7..D4, enable, register select) plus the number of delay units to hold
// it; tlast marks the final state of a request. A byte goes out as seven
// states, a cursor move as eight (command plus a settle pause), the init
// request as 44. One output item leaves per cycle while the sink is ready.
// A cursor move keeps the front end busy while it queues the settle pause.
// Init keeps it busy until all eight of its jobs are queued; the four-entry
// queue fills on the way, and sink stalls make this longer.
// With a free queue it takes the next request while the previous one is
// still being played out.
// Hold counts come from step_hold (index 0) and cursor_settle_hold (index 1),
// written through the cfg port; the user must write them only while the
// block is idle, which the block itself does not enforce. cfg_ready is
// always high and writes to other indexes are ignored.
// ---------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = LCDNW_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // byte_value[7:0], column[13:8], row[16:14]
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // op[1:0]
	// pin state stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // data_nibble[3:0], enable[4], hold_count[20:5]
	output logic                   m_tuser,   // reg_select
	output logic                   m_tlast,   // last
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic q_full;
	logic q_empty;
	logic q_pop;
	logic push_valid;
	job_t push_job;
	job_t q_head;

	// registers are plain flops, so a write is always taken
	assign cfg_ready = 1'b1;

	// front: decode and expand requests into jobs
	lcdnw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	// decoupling queue
	lcdnw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// back: per-cycle pin sequencer, holds pin state and hold registers
	lcdnw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ rtl/lcdnw_front.sv @@
// ---------------------------------------------------------------------------
// lcdnw_front
// Accepts requests and breaks them into byte and pause jobs for the queue.
// ---------------------------------------------------------------------------
module lcdnw_front import lcdnw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [IN_TUSER_W-1:0] s_tuser,
	input  logic                  q_full,
	output logic                  push_valid,
	output job_t                  push_job
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_INIT,
		F_CURSOR
	} fstate_t;

	fstate_t    state_q;
	logic [2:0] init_idx_q;

	logic [7:0] byte_value;
	logic [5:0] column;
	logic [2:0] row;
	logic [7:0] cursor_addr;
	op_t        op;
	logic       accept;

	assign byte_value  = s_tdata[7:0];
	assign column      = s_tdata[13:8];
	assign row         = s_tdata[16:14];
	assign op          = op_t'(s_tuser);
	assign cursor_addr = row_base(row) + {2'b00, column} - 8'd1;

	assign s_tready = (state_q == F_IDLE) && !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		push_valid = 1'b0;
		push_job   = pause_job(1'b0, 1'b0);
		case (state_q)
			F_IDLE: begin
				push_valid = accept;
				case (op)
					OP_INIT:   push_job = init_job(3'd0);
					OP_CMD:    push_job = byte_job(1'b0, byte_value, 1'b1);
					OP_DATA:   push_job = byte_job(1'b1, byte_value, 1'b1);
					OP_CURSOR: push_job = byte_job(1'b0, cursor_addr, 1'b0);
					default:   push_job = pause_job(1'b0, 1'b0);
				endcase
			end
			F_INIT: begin
				push_valid = !q_full;
				push_job   = init_job(init_idx_q);
			end
			F_CURSOR: begin
				push_valid = !q_full;
				push_job   = pause_job(1'b1, 1'b1);
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			init_idx_q <= 3'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						init_idx_q <= 3'd1;
						if (op == OP_INIT) begin
							state_q <= F_INIT;
						end else if (op == OP_CURSOR) begin
							state_q <= F_CURSOR;
						end
					end
				end
				F_INIT: begin
					if (!q_full) begin
						init_idx_q <= init_idx_q + 3'd1;
						if (init_idx_q == INIT_LAST_IDX) begin
							state_q <= F_IDLE;
						end
					end
				end
				F_CURSOR: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/lcdnw_queue.sv @@
// ---------------------------------------------------------------------------
// lcdnw_queue
// Small job queue between the request front end and the pin sequencer.
// ---------------------------------------------------------------------------
module lcdnw_queue import lcdnw_pkg::*; #(
	parameter int unsigned DEPTH = LCDNW_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_MAX);
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/lcdnw_back.sv @@
// ---------------------------------------------------------------------------
// lcdnw_back
// Plays jobs out as pin states, one per cycle while the output is not stalled, into a registered output.
// ---------------------------------------------------------------------------
module lcdnw_back import lcdnw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  job_t                   head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic [HOLD_W-1:0] step_hold_q;
	logic [HOLD_W-1:0] settle_hold_q;
	logic [3:0]        pin_nibble_q;
	logic              pin_select_q;
	logic [2:0]        step_q;

	logic              out_valid_q;
	logic [3:0]        out_nibble_q;
	logic              out_select_q;
	logic              out_enable_q;
	logic [HOLD_W-1:0] out_hold_q;
	logic              out_last_q;

	logic              advance;
	logic              job_done;
	logic [3:0]        nxt_nibble;
	logic              nxt_select;
	logic              nxt_enable;
	logic [HOLD_W-1:0] nxt_hold;
	logic              nxt_last;

	assign advance  = !empty && (!out_valid_q || m_tready);
	assign job_done = (head.kind == JOB_PAUSE) || (step_q == 3'd6);
	assign pop      = advance && job_done;

	always_comb begin
		nxt_nibble = pin_nibble_q;
		nxt_select = head.sel;
		nxt_enable = 1'b0;
		nxt_hold   = step_hold_q;
		nxt_last   = 1'b0;
		if (head.kind == JOB_PAUSE) begin
			nxt_select = pin_select_q;
			nxt_hold   = head.settle ? settle_hold_q : step_hold_q;
			nxt_last   = head.last;
		end else begin
			case (step_q)
				3'd0: nxt_nibble = pin_nibble_q;
				3'd1: nxt_nibble = head.val[7:4];
				3'd2: begin
					nxt_nibble = head.val[7:4];
					nxt_enable = 1'b1;
				end
				3'd3: nxt_nibble = head.val[7:4];
				3'd4: begin
					// enable rise follows straight away
					nxt_nibble = head.val[3:0];
					nxt_hold   = '0;
				end
				3'd5: begin
					nxt_nibble = head.val[3:0];
					nxt_enable = 1'b1;
				end
				default: begin
					nxt_nibble = head.val[3:0];
					nxt_last   = head.last;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_hold_q   <= STEP_HOLD_RESET;
			settle_hold_q <= SETTLE_HOLD_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_STEP_HOLD) begin
				step_hold_q <= cfg_data;
			end else if (cfg_index == REG_SETTLE_HOLD) begin
				settle_hold_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_nibble_q <= '0;
			pin_select_q <= 1'b0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= job_done ? 3'd0 : step_q + 3'd1;
				if (head.kind == JOB_BYTE) begin
					if (step_q == 3'd0) begin
						pin_select_q <= head.sel;
					end
					if (step_q == 3'd1 || step_q == 3'd4) begin
						pin_nibble_q <= nxt_nibble;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_nibble_q <= nxt_nibble;
			out_select_q <= nxt_select;
			out_enable_q <= nxt_enable;
			out_hold_q   <= nxt_hold;
			out_last_q   <= nxt_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_hold_q, out_enable_q, out_nibble_q};
	assign m_tuser  = out_select_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/lcdnw_checker.sv @@
// ---------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks on the LCD nibble write sequencer, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdnw_checker import lcdnw_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TUSER_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// a stalled pin state stays put
	`LCDNW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "pin state changed while stalled")

	// an enable-high state is never the end of a request
	`LCDNW_ASSERT_SAME(a_en_not_last, m_tvalid && m_tdata[4], !m_tlast, "request ended with enable high")

	// init and cursor requests keep the front busy for the next cycle
	`LCDNW_ASSERT_NEXT(a_multi_busy, s_tvalid && s_tready && (s_tuser == OP_INIT || s_tuser == OP_CURSOR), !s_tready, "front took a request while expanding")

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_lcdnw_checker (.*);

@@ tb/sv/char_lcd_pin_checker.sv @@
// ---------------------------------------------------------------------------
// char_lcd_pin_checker
// Predicts the pin states of the LCD nibble write sequencer and compares.
// ---------------------------------------------------------------------------
// Watches the request, pin state and configuration channels. Every accepted
// request is expanded into the pin states it should produce. Every accepted
// pin state is compared field by field with the oldest one still owed.
// ---------------------------------------------------------------------------
module char_lcd_pin_checker import lcdnw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // byte_value[7:0], column[13:8], row[16:14]
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // op[1:0]
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // data_nibble[3:0], enable[4], hold_count[20:5]
	input  logic                   m_tuser,   // reg_select
	input  logic                   m_tlast,   // last
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pins_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]        nibble;
		logic              sel;
		logic              en;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_state_t;

	localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hc0, 8'h94, 8'hd4};

	pin_state_t        owed_pins[$];
	pin_state_t        seen_pin;
	pin_state_t        want_pin;
	logic [HOLD_W-1:0] step_hold_q   = STEP_HOLD_RESET;
	logic [HOLD_W-1:0] settle_hold_q = SETTLE_HOLD_RESET;
	logic [3:0]        lines_nibble  = 4'd0;
	logic              lines_sel     = 1'b0;

	initial begin
		errors    = 0;
		pins_owed = 0;
	end

	task automatic report_fault(input string msg);
		$display("[%0t] pin check: %s", $realtime, msg);
		errors++;
	endtask

	// one pin state at the current line levels
	function automatic void owe_pin(input logic en, input logic [HOLD_W-1:0] hold);
		pin_state_t p;
		p.nibble = lines_nibble;
		p.sel    = lines_sel;
		p.en     = en;
		p.hold   = hold;
		p.last   = 1'b0;
		owed_pins.push_back(p);
	endfunction

	// seven states per byte; low nibble setup has no hold
	function automatic void owe_byte(input logic sel, input logic [7:0] val);
		lines_sel = sel;
		owe_pin(1'b0, step_hold_q);
		lines_nibble = val[7:4];
		owe_pin(1'b0, step_hold_q);
		owe_pin(1'b1, step_hold_q);
		owe_pin(1'b0, step_hold_q);
		lines_nibble = val[3:0];
		owe_pin(1'b0, '0);
		owe_pin(1'b1, step_hold_q);
		owe_pin(1'b0, step_hold_q);
	endfunction

	function automatic void owe_request(input op_t op, input logic [7:0] val,
			input logic [5:0] col, input logic [2:0] row);
		logic [1:0] row_idx;
		logic [7:0] addr;
		row_idx = row[1:0] - 2'd1;   // (row - 1) mod 4
		addr    = ROW_BASE[row_idx] + {2'b00, col} - 8'd1;
		case (op)
			OP_INIT: begin
				owe_pin(1'b0, step_hold_q);
				owe_byte(1'b0, INIT_B0);
				owe_byte(1'b0, INIT_B1);
				owe_byte(1'b0, INIT_B2);
				owe_byte(1'b0, INIT_B3);
				owe_byte(1'b0, INIT_B4);
				owe_pin(1'b0, step_hold_q);   // wait after display clear
				owe_byte(1'b0, INIT_B5);
			end
			OP_CMD:  owe_byte(1'b0, val);
			OP_DATA: owe_byte(1'b1, val);
			default: begin
				owe_byte(1'b0, addr);
				owe_pin(1'b0, settle_hold_q);
			end
		endcase
		owed_pins[owed_pins.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_pins.delete();
			step_hold_q   = STEP_HOLD_RESET;
			settle_hold_q = SETTLE_HOLD_RESET;
			lines_nibble  = 4'd0;
			lines_sel     = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STEP_HOLD)
					step_hold_q = cfg_data;
				else if (cfg_index == REG_SETTLE_HOLD)
					settle_hold_q = cfg_data;
			end
			if (s_tvalid && s_tready)
				owe_request(op_t'(s_tuser), s_tdata[7:0], s_tdata[13:8], s_tdata[16:14]);
			if (m_tvalid && m_tready) begin
				seen_pin.nibble = m_tdata[3:0];
				seen_pin.en     = m_tdata[4];
				seen_pin.hold   = m_tdata[20:5];
				seen_pin.sel    = m_tuser;
				seen_pin.last   = m_tlast;
				if (owed_pins.size() == 0) begin
					report_fault($sformatf("pin state with none owed: %h", seen_pin));
				end else begin
					want_pin = owed_pins.pop_front();
					if (seen_pin.nibble !== want_pin.nibble)
						report_fault($sformatf("data_nibble %h, expected %h",
							seen_pin.nibble, want_pin.nibble));
					if (seen_pin.sel !== want_pin.sel)
						report_fault($sformatf("reg_select %b, expected %b",
							seen_pin.sel, want_pin.sel));
					if (seen_pin.en !== want_pin.en)
						report_fault($sformatf("enable %b, expected %b",
							seen_pin.en, want_pin.en));
					if (seen_pin.hold !== want_pin.hold)
						report_fault($sformatf("hold_count %0d, expected %0d",
							seen_pin.hold, want_pin.hold));
					if (seen_pin.last !== want_pin.last)
						report_fault($sformatf("last %b, expected %b",
							seen_pin.last, want_pin.last));
				end
			end
		end
		pins_owed = owed_pins.size();
	end

endmodule

@@ tb/sv/char_lcd_nibble_write_sequencer_tb.sv @@
// ---------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_tb
// Request stimulus and verdict for the LCD nibble write sequencer.
// ---------------------------------------------------------------------------
// A short directed run at the reset hold counts covers init, command and
// data bytes at their extremes and cursor moves over every row, the rows
// outside 1..4 and address wrap. Four random phases follow, each with its own
// hold counts and its own mix of sender gaps and receiver stalls. The pin
// checker beside the block does the prediction and comparison.
// ---------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcdnw_pkg::*;

	localparam int ITEMS_PER_PHASE = 70;
	localparam int DRAIN_CYCLES    = 40;   // well past the delay from request to first pin state

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // byte_value[7:0], column[13:8], row[16:14]
	logic [IN_TUSER_W-1:0]  s_tuser   = '0;   // op[1:0]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // data_nibble[3:0], enable[4], hold_count[20:5]
	logic                   m_tuser;          // reg_select
	logic                   m_tlast;          // last
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int fail_count;
	int pins_owed;
	int tx_idle_pct  = 0;   // chance per cycle that the sender holds back
	int rx_stall_pct = 0;   // chance per cycle that the receiver stalls

	always #5ns clk = ~clk;

	char_lcd_nibble_write_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	char_lcd_pin_checker u_pin_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pins_owed (pins_owed)
	);

	// receiver: ready redrawn every falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// called just after a falling edge; returns just after one, having
	// assigned nothing in that step, so valid can stay high for the next item
	task automatic send_request(input op_t op, input logic [7:0] val,
			input logic [5:0] col, input logic [2:0] row);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, row, col, val};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drop valid and hold off until the checker owes nothing;
	// always waits for a falling edge so valid is not re-raised in this step
	task automatic wait_all_pins();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pins_owed != 0);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// block idle: set both hold counts, poke an unused index, set the idling mix
	task automatic start_phase(input int tx, input int rx,
			input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] settle);
		wait_all_pins();
		write_reg(REG_STEP_HOLD, step);
		write_reg(REG_SETTLE_HOLD, settle);
		write_reg(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
		cfg_valid    <= 1'b0;
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
	endtask

	// run limit, far beyond the slowest legal run
	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int         pick;
		op_t        op;
		logic [7:0] val;
		logic [5:0] col;
		logic [2:0] row;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, at the reset hold counts
		send_request(OP_INIT,   8'h00, 6'd0,  3'd0);
		send_request(OP_CMD,    8'h00, 6'd63, 3'd7);
		send_request(OP_CMD,    8'hff, 6'd0,  3'd0);
		send_request(OP_DATA,   8'hff, 6'd63, 3'd7);
		send_request(OP_DATA,   8'h00, 6'd0,  3'd0);
		send_request(OP_DATA,   8'h5a, 6'd21, 3'd2);
		send_request(OP_CURSOR, 8'hff, 6'd1,  3'd1);
		send_request(OP_CURSOR, 8'h00, 6'd40, 3'd2);
		send_request(OP_CURSOR, 8'ha5, 6'd1,  3'd3);
		send_request(OP_CURSOR, 8'h3c, 6'd20, 3'd4);
		send_request(OP_CURSOR, 8'h00, 6'd40, 3'd4);
		// rows outside 1..4 fold back by (row - 1) mod 4
		send_request(OP_CURSOR, 8'h00, 6'd1,  3'd0);
		send_request(OP_CURSOR, 8'h00, 6'd3,  3'd5);
		send_request(OP_CURSOR, 8'h00, 6'd3,  3'd6);
		send_request(OP_CURSOR, 8'h00, 6'd3,  3'd7);
		// columns outside 1..40, address wrapping past 0xff and below 0x80
		send_request(OP_CURSOR, 8'h00, 6'd0,  3'd1);
		send_request(OP_CURSOR, 8'h00, 6'd63, 3'd4);
		send_request(OP_CURSOR, 8'h00, 6'd44, 3'd4);
		send_request(OP_CURSOR, 8'h00, 6'd45, 3'd4);
		// init again from non-zero pin levels, unused fields all ones
		send_request(OP_INIT,   8'hff, 6'd63, 3'd7);
		send_request(OP_CMD,    8'h01, 6'd0,  3'd0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: start_phase(0, 0, 16'd0, 16'hffff);
				1: start_phase(70, 0, 16'hffff, 16'd0);
				2: start_phase(0, 70, 16'($urandom), 16'($urandom));
				default: start_phase(38, 38, 16'($urandom), 16'($urandom));
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// let the pipeline run dry once per phase mid-stream
				if (i == ITEMS_PER_PHASE / 2)
					wait_all_pins();
				pick = $urandom_range(0, 99);
				val  = 8'($urandom);
				col  = 6'($urandom);
				row  = 3'($urandom);
				if (pick < 6) begin
					op = OP_INIT;
				end else if (pick < 36) begin
					op = OP_CMD;
				end else if (pick < 70) begin
					op = OP_DATA;
				end else begin
					op = OP_CURSOR;
					// mostly on-screen positions, some anywhere in the field range
					if ($urandom_range(0, 9) < 8) begin
						col = 6'($urandom_range(1, 40));
						row = 3'($urandom_range(1, 4));
					end
				end
				send_request(op, val, col, row);
			end
		end

		// drain with the receiver always ready, then watch for strays
		s_tvalid     <= 1'b0;
		rx_stall_pct = 0;
		do @(negedge clk); while (pins_owed != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
